### hw/rtl/lpd_pkg.sv
// Shared types, constants and power curves for the laser power drive.
package lpd_pkg;

  // Fixed-point format of the power fields (unsigned Q7.8 percent)
  localparam int FRAC_BITS     = 8;
  localparam int REQ_W         = 16;
  localparam int POWER_W       = 15;
  localparam int DUTY_W        = 8;
  localparam int CURVE_ENTRIES = 101;
  localparam int IDX_W         = $clog2(CURVE_ENTRIES);
  localparam logic [IDX_W-1:0]   CURVE_TOP    = IDX_W'(CURVE_ENTRIES - 1);
  localparam logic [POWER_W-1:0] FULL_POWER_Q = POWER_W'(100 << FRAC_BITS);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_SWITCH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_DELAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DELAY = 3'd4;

  // Register reset values
  localparam int FAN_DELAY_RST    = 5 * 600;
  localparam int SWITCH_DELAY_RST = 2 * 10;

  // Request kinds
  localparam logic CMD_SET_POWER = 1'b0;
  localparam logic CMD_TICK      = 1'b1;

  // Delayed-off machine state
  typedef enum logic [1:0] {
    ST_CLOSED = 2'd0,
    ST_OPEN   = 2'd1,
    ST_WAIT   = 2'd2
  } lpd_state_t;

  // Command issued to the fan or master switch
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } lpd_act_t;

  // Control from the datapath to one delayed-off machine
  typedef struct packed {
    logic step;     // a request is being processed
    logic tick;     // the request is a 100 ms tick
    logic duty_nz;  // new duty is non-zero
  } lpd_mach_ctl_t;

  // Low-power head curve, duty per integer percent
  localparam logic [DUTY_W-1:0] CURVE_LOW [CURVE_ENTRIES] = '{
    8'd0,
    8'd20,  8'd22,  8'd24,  8'd26,  8'd28,  8'd30,  8'd31,  8'd33,  8'd35,  8'd37,
    8'd39,  8'd41,  8'd43,  8'd45,  8'd47,  8'd49,  8'd51,  8'd53,  8'd54,  8'd56,
    8'd58,  8'd60,  8'd63,  8'd65,  8'd67,  8'd69,  8'd71,  8'd73,  8'd75,  8'd77,
    8'd79,  8'd82,  8'd84,  8'd86,  8'd88,  8'd90,  8'd93,  8'd95,  8'd97,
    8'd100, 8'd102, 8'd103, 8'd106, 8'd109, 8'd111, 8'd113, 8'd116, 8'd119, 8'd121,
    8'd123, 8'd125, 8'd128, 8'd130, 8'd133, 8'd135, 8'd138, 8'd140, 8'd143, 8'd145,
    8'd148, 8'd150, 8'd153, 8'd156, 8'd158, 8'd161, 8'd164, 8'd166, 8'd169,
    8'd171, 8'd174, 8'd177, 8'd179, 8'd182, 8'd185, 8'd187, 8'd190, 8'd192, 8'd196,
    8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd211, 8'd214, 8'd217, 8'd218,
    8'd221, 8'd224, 8'd226, 8'd228, 8'd231, 8'd234, 8'd236, 8'd240, 8'd242,
    8'd247, 8'd251, 8'd255
  };

  // Ten-watt head curve
  localparam logic [DUTY_W-1:0] CURVE_HIGH [CURVE_ENTRIES] = '{
    8'd0,   8'd27,  8'd27,  8'd29,  8'd32,  8'd35,  8'd37,  8'd40,  8'd42,  8'd45,
    8'd47,  8'd49,  8'd51,  8'd54,  8'd56,  8'd59,  8'd61,  8'd63,  8'd65,  8'd68,
    8'd70,  8'd72,  8'd75,  8'd77,  8'd79,  8'd82,  8'd84,  8'd87,  8'd90,  8'd92,
    8'd94,  8'd97,  8'd99,  8'd101, 8'd103, 8'd106, 8'd108, 8'd110, 8'd112, 8'd115,
    8'd117, 8'd120, 8'd122, 8'd124, 8'd126, 8'd128, 8'd131, 8'd133, 8'd135, 8'd138,
    8'd140, 8'd142, 8'd144, 8'd147, 8'd149, 8'd151, 8'd153, 8'd156, 8'd158, 8'd161,
    8'd163, 8'd166, 8'd168, 8'd171, 8'd173, 8'd176, 8'd178, 8'd180, 8'd182, 8'd185,
    8'd188, 8'd190, 8'd192, 8'd193, 8'd195, 8'd198, 8'd200, 8'd202, 8'd204, 8'd207,
    8'd209, 8'd212, 8'd214, 8'd216, 8'd218, 8'd221, 8'd224, 8'd226, 8'd228, 8'd230,
    8'd233, 8'd235, 8'd239, 8'd241, 8'd242, 8'd245, 8'd247, 8'd250, 8'd252, 8'd254,
    8'd255
  };

endpackage

### hw/rtl/lpd_ifs.sv
// Request and result channel interfaces of the laser power drive.
interface lpd_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] power_q8;

  modport source (output valid, cmd, power_q8, input ready);
  modport sink   (input valid, cmd, power_q8, output ready);
endinterface

interface lpd_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          pwm_duty;
  logic [14:0]         applied_power_q8;
  logic                tube_on;
  lpd_pkg::lpd_state_t fan_mode;
  lpd_pkg::lpd_state_t switch_mode;
  lpd_pkg::lpd_act_t   fan_command;
  lpd_pkg::lpd_act_t   switch_command;

  modport source (output valid, pwm_duty, applied_power_q8, tube_on, fan_mode,
                  switch_mode, fan_command, switch_command, input ready);
  modport sink   (input valid, pwm_duty, applied_power_q8, tube_on, fan_mode,
                  switch_mode, fan_command, switch_command, output ready);
endinterface

### hw/rtl/laser_power_drive_with_delayed_off_unit.sv
// Top level of the laser power drive with delayed-off fan and master switch.
//
// Usage: each request on in_ch is either a power setting (cmd 0, power_q8 in
// unsigned Q8.8 percent) or one 100 ms tick (cmd 1). Every request yields
// exactly one result on out_ch: the drive duty, the clamped power, tube on,
// the fan and switch modes and any fan or switch command raised by it.
// Registers are to be written through cfg_we / cfg_index / cfg_data only while
// no request is in flight, which the block does not check; a write lands at the clock edge.
// The request lands in the input register at its accepting edge and moves
// into the result register, which raises out_ch.valid, once the result side
// is free. Throughput: one request per cycle while out_ch.ready is high; the
// curve lookup, interpolation multiply and machine updates all sit in the
// single stage between the two registers.
// Reset (rst_n low, synchronous): both channels empty, duty and power zero,
// both machines closed, registers at 100.0 limit, low-power curve, switch
// disabled, fan delay 3000 ticks, switch delay 20 ticks.
// Stall: when out_ch.ready is low the result is held and the input register
// keeps one more request; in_ch.ready falls only when both are full.
module laser_power_drive_with_delayed_off_unit #(
  parameter  int DELAY_BITS = 12,
  localparam int CfgW       = (DELAY_BITS > lpd_pkg::POWER_W) ? DELAY_BITS : lpd_pkg::POWER_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lpd_in_if.sink                          in_ch,
  lpd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CfgW-1:0]                 cfg_data
);
  import lpd_pkg::*;

  // Configuration registers
  logic [POWER_W-1:0]    limit_r;
  logic                  tsel_r;
  logic                  msw_r;
  logic [DELAY_BITS-1:0] fan_dly_r;
  logic [DELAY_BITS-1:0] sw_dly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= FULL_POWER_Q;
      tsel_r    <= 1'b0;
      msw_r     <= 1'b0;
      fan_dly_r <= DELAY_BITS'(FAN_DELAY_RST);
      sw_dly_r  <= DELAY_BITS'(SWITCH_DELAY_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT:        limit_r   <= cfg_data[POWER_W-1:0];
        CFG_TABLE_SELECT: tsel_r    <= cfg_data[0];
        CFG_HAS_SWITCH:   msw_r     <= cfg_data[0];
        CFG_FAN_DELAY:    fan_dly_r <= cfg_data[DELAY_BITS-1:0];
        CFG_SWITCH_DELAY: sw_dly_r  <= cfg_data[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             s1_cmd_r;
  logic [REQ_W-1:0] s1_power_r;
  logic             s1_go;
  logic             in_take;
  logic             out_valid_r;
  logic             out_valid_nxt;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_ch.cmd;
      s1_power_r <= in_ch.power_q8;
    end
  end

  // Curve lookup and interpolation
  logic [POWER_W-1:0] interp_power;
  logic [DUTY_W-1:0]  new_duty;

  lpd_curve_interp u_interp (
    .power_q8      (s1_power_r),
    .cap_q8        (limit_r),
    .table_sel     (tsel_r),
    .applied_power (interp_power),
    .duty          (new_duty)
  );

  // Held duty and power; a power setting replaces them
  logic               is_set;
  logic [DUTY_W-1:0]  duty_r;
  logic [DUTY_W-1:0]  duty_nxt;
  logic [POWER_W-1:0] power_r;
  logic [POWER_W-1:0] power_nxt;

  assign is_set    = (s1_cmd_r == CMD_SET_POWER);
  assign duty_nxt  = is_set ? new_duty : duty_r;
  assign power_nxt = is_set ? interp_power : power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r  <= '0;
      power_r <= '0;
    end else if (s1_go) begin
      duty_r  <= duty_nxt;
      power_r <= power_nxt;
    end
  end

  // Fan and master switch machines
  lpd_mach_ctl_t fan_ctl;
  lpd_mach_ctl_t sw_ctl;
  lpd_state_t    fan_mode;
  lpd_state_t    sw_mode;
  lpd_act_t      fan_act;
  lpd_act_t      sw_act;

  assign fan_ctl = '{step: s1_go, tick: s1_cmd_r, duty_nz: (new_duty != '0)};
  assign sw_ctl  = '{step: s1_go && msw_r, tick: s1_cmd_r, duty_nz: (new_duty != '0)};

  lpd_delay_off #(.DELAY_BITS(DELAY_BITS)) u_fan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fan_ctl),
    .delay    (fan_dly_r),
    .mode_nxt (fan_mode),
    .command  (fan_act)
  );

  lpd_delay_off #(.DELAY_BITS(DELAY_BITS)) u_switch (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sw_ctl),
    .delay    (sw_dly_r),
    .mode_nxt (sw_mode),
    .command  (sw_act)
  );

  // Result register
  logic [DUTY_W-1:0]  o_duty_r;
  logic [POWER_W-1:0] o_power_r;
  lpd_state_t         o_fan_mode_r;
  lpd_state_t         o_sw_mode_r;
  lpd_act_t           o_fan_act_r;
  lpd_act_t           o_sw_act_r;

  always_comb begin
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      o_duty_r     <= duty_nxt;
      o_power_r    <= power_nxt;
      o_fan_mode_r <= fan_mode;
      o_sw_mode_r  <= sw_mode;
      o_fan_act_r  <= fan_act;
      o_sw_act_r   <= sw_act;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.pwm_duty         = o_duty_r;
  assign out_ch.applied_power_q8 = o_power_r;
  assign out_ch.tube_on          = (o_duty_r != '0);
  assign out_ch.fan_mode         = o_fan_mode_r;
  assign out_ch.switch_mode      = o_sw_mode_r;
  assign out_ch.fan_command      = o_fan_act_r;
  assign out_ch.switch_command   = o_sw_act_r;

  // An on command always leaves the fan open
  a_fan_on_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.fan_command == ACT_ON) |-> out_ch.fan_mode == ST_OPEN)
    else $error("fan on command without open mode");

  // An off command always leaves the fan closed
  a_fan_off_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.fan_command == ACT_OFF) |-> out_ch.fan_mode == ST_CLOSED)
    else $error("fan off command without closed mode");

  // Applied power never exceeds full scale
  a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.applied_power_q8 <= FULL_POWER_Q)
    else $error("applied power above 100 percent");

  // A request sitting in the input register moves on when the result side frees
  a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("input register did not advance into empty result register");

endmodule

### hw/rtl/lpd_curve_interp.sv
// Power clamp and linear interpolation over the selected power curve.
module lpd_curve_interp (
  input  logic [lpd_pkg::REQ_W-1:0]   power_q8,
  input  logic [lpd_pkg::POWER_W-1:0] cap_q8,
  input  logic                        table_sel,
  output logic [lpd_pkg::POWER_W-1:0] applied_power,
  output logic [lpd_pkg::DUTY_W-1:0]  duty
);
  import lpd_pkg::*;

  logic [POWER_W-1:0]     req_sat;
  logic [POWER_W-1:0]     lim_sat;
  logic [POWER_W-1:0]     p;
  logic [IDX_W-1:0]       idx_a;
  logic [IDX_W-1:0]       idx_b;
  logic [FRAC_BITS-1:0]   frac;
  logic [FRAC_BITS:0]     w_a;
  logic [DUTY_W-1:0]      c_a;
  logic [DUTY_W-1:0]      c_b;
  logic [DUTY_W+FRAC_BITS:0] sum;

  // Saturate request and limit to 100 percent, then request to limit
  always_comb begin
    req_sat = (power_q8 > REQ_W'(FULL_POWER_Q)) ? FULL_POWER_Q : power_q8[POWER_W-1:0];
    lim_sat = (cap_q8 > FULL_POWER_Q) ? FULL_POWER_Q : cap_q8;
    p       = (req_sat > lim_sat) ? lim_sat : req_sat;
  end

  // Curve neighbors; the top entry is its own upper neighbor
  always_comb begin
    frac  = p[FRAC_BITS-1:0];
    idx_a = p[FRAC_BITS+IDX_W-1:FRAC_BITS];
    if (idx_a >= CURVE_TOP) begin
      idx_a = CURVE_TOP;
      idx_b = CURVE_TOP;
    end else begin
      idx_b = idx_a + IDX_W'(1);
    end
    c_a = table_sel ? CURVE_HIGH[idx_a] : CURVE_LOW[idx_a];
    c_b = table_sel ? CURVE_HIGH[idx_b] : CURVE_LOW[idx_b];
  end

  // Weighted sum, truncated; never exceeds full scale
  always_comb begin
    w_a  = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac};
    sum  = (DUTY_W+FRAC_BITS+1)'(c_a * w_a) + (DUTY_W+FRAC_BITS+1)'(c_b * frac);
    duty = sum[DUTY_W+FRAC_BITS-1:FRAC_BITS];
  end

  assign applied_power = p;

endmodule

### hw/rtl/lpd_delay_off.sv
// Delayed-off machine: opens on non-zero duty, closes after a tick delay at zero.
module lpd_delay_off #(
  parameter int DELAY_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpd_pkg::lpd_mach_ctl_t ctl,
  input  logic [DELAY_BITS-1:0]  delay,
  output lpd_pkg::lpd_state_t    mode_nxt,
  output lpd_pkg::lpd_act_t      command
);
  import lpd_pkg::*;

  lpd_state_t            state_r;
  lpd_state_t            state_nxt;
  logic [DELAY_BITS-1:0] count_r;
  logic [DELAY_BITS-1:0] count_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLOSED;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    command   = ACT_NONE;
    if (ctl.step) begin
      if (ctl.tick) begin
        if (state_r == ST_WAIT) begin
          if (count_r < delay) begin
            count_nxt = count_r + DELAY_BITS'(1);
          end else begin
            state_nxt = ST_CLOSED;
            command   = ACT_OFF;
          end
        end
      end else begin
        case (state_r)
          ST_OPEN: begin
            if (!ctl.duty_nz) begin
              state_nxt = ST_WAIT;
              count_nxt = '0;
            end
          end
          ST_WAIT: begin
            if (ctl.duty_nz) begin
              state_nxt = ST_OPEN;
              count_nxt = '0;
            end
          end
          ST_CLOSED: begin
            if (ctl.duty_nz) begin
              state_nxt = ST_OPEN;
              command   = ACT_ON;
            end
          end
          default: begin
            state_nxt = ST_CLOSED;
          end
        endcase
      end
    end
  end

  assign mode_nxt = state_nxt;

endmodule

### sim/laser_power_drive_with_delayed_off_unit_tb.sv
// Self-checking testbench for the laser power drive: curve lookup, clamping and delayed-off fsms.
module laser_power_drive_with_delayed_off_unit_tb;
  import lpd_pkg::*;

  localparam int STALL_MAX    = 18;
  localparam int IDLE_LIMIT   = 500;   // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
  localparam int CFG_W        = POWER_W;
  localparam int PHASE_ITEMS  = 210;
  localparam int PHASES       = 8;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [POWER_W-1:0] power;
    logic               tube_on;
    lpd_state_t         fan_mode;
    lpd_state_t         switch_mode;
    lpd_act_t           fan_cmd;
    lpd_act_t           switch_cmd;
  } drive_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lpd_in_if  in_ch ();
  lpd_out_if out_ch ();

  laser_power_drive_with_delayed_off_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers and machine state of the drive
  logic [POWER_W-1:0] lim_q8      = FULL_POWER_Q;
  logic               head_10w    = 1'b0;
  logic               switch_en   = 1'b0;
  logic [11:0]        fan_delay   = 12'(FAN_DELAY_RST);
  logic [11:0]        sw_delay    = 12'(SWITCH_DELAY_RST);
  logic [DUTY_W-1:0]  duty_now    = '0;
  logic [POWER_W-1:0] power_now   = '0;
  lpd_state_t         fan_st      = ST_CLOSED;
  lpd_state_t         sw_st       = ST_CLOSED;
  logic [11:0]        fan_cnt     = '0;
  logic [11:0]        sw_cnt      = '0;

  drive_result_t pending_results[$];
  int            errors      = 0;
  int            tx_mode     = 0;
  int            rx_mode     = 0;
  int            idle_cycles = 0;

  // 0: random waits, 1: no waits, 2: mostly back-to-back with rare long gaps
  function automatic int draw_wait(int mode);
    case (mode)
      1: return 0;
      2: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, STALL_MAX)) : 0;
      default: return $urandom_range(0, STALL_MAX);
    endcase
  endfunction

  function automatic int curve_entry(int idx);
    return head_10w ? int'(CURVE_HIGH[idx]) : int'(CURVE_LOW[idx]);
  endfunction

  // Linear interpolation between neighboring curve points, top index clamped
  function automatic logic [DUTY_W-1:0] duty_for_power(logic [POWER_W-1:0] p);
    int idx, nxt, frac, acc;
    idx  = int'(p) >> FRAC_BITS;
    frac = int'(p) & ((1 << FRAC_BITS) - 1);
    nxt  = idx + 1;
    if (idx >= CURVE_ENTRIES - 1) begin
      idx = CURVE_ENTRIES - 1;
      nxt = CURVE_ENTRIES - 1;
    end
    acc = (curve_entry(idx) * ((1 << FRAC_BITS) - frac) + curve_entry(nxt) * frac) >> FRAC_BITS;
    if (acc > 255) acc = 255;
    return acc[DUTY_W-1:0];
  endfunction

  task automatic fsm_on_duty(inout lpd_state_t st, inout logic [11:0] cnt,
                             input logic [DUTY_W-1:0] duty, output lpd_act_t act);
    act = ACT_NONE;
    case (st)
      ST_OPEN: begin
        if (duty == 0) begin
          st  = ST_WAIT;
          cnt = '0;
        end
      end
      ST_WAIT: begin
        if (duty != 0) begin
          st  = ST_OPEN;
          cnt = '0;
        end
      end
      ST_CLOSED: begin
        if (duty != 0) begin
          st  = ST_OPEN;
          act = ACT_ON;
        end
      end
      default: ;
    endcase
  endtask

  task automatic fsm_on_tick(inout lpd_state_t st, inout logic [11:0] cnt,
                             input logic [11:0] delay, output lpd_act_t act);
    act = ACT_NONE;
    if (st == ST_WAIT) begin
      if (cnt < delay) begin
        cnt = cnt + 12'd1;
      end else begin
        st  = ST_CLOSED;
        act = ACT_OFF;
      end
    end
  endtask

  // Work out the result of one accepted request and queue it
  task automatic predict_drive(logic c, logic [REQ_W-1:0] req);
    logic [REQ_W-1:0]   p;
    logic [POWER_W-1:0] lim;
    drive_result_t      r;
    r.fan_cmd    = ACT_NONE;
    r.switch_cmd = ACT_NONE;
    if (c == CMD_SET_POWER) begin
      p   = (req > FULL_POWER_Q) ? REQ_W'(FULL_POWER_Q) : req;
      lim = (lim_q8 > FULL_POWER_Q) ? FULL_POWER_Q : lim_q8;
      if (p > lim) p = REQ_W'(lim);
      power_now = p[POWER_W-1:0];
      duty_now  = duty_for_power(power_now);
      fsm_on_duty(fan_st, fan_cnt, duty_now, r.fan_cmd);
      if (switch_en) fsm_on_duty(sw_st, sw_cnt, duty_now, r.switch_cmd);
    end else begin
      fsm_on_tick(fan_st, fan_cnt, fan_delay, r.fan_cmd);
      if (switch_en) fsm_on_tick(sw_st, sw_cnt, sw_delay, r.switch_cmd);
    end
    r.duty        = duty_now;
    r.power       = power_now;
    r.tube_on     = (duty_now != 0);
    r.fan_mode    = fan_st;
    r.switch_mode = sw_st;
    pending_results.push_back(r);
  endtask

  // Send one request, with a random gap before it
  task automatic send_request(logic c, logic [REQ_W-1:0] p);
    int gap;
    gap = draw_wait(tx_mode);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.cmd      = c;
    in_ch.power_q8 = p;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_drive(c, p);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_request(CMD_TICK, REQ_W'($urandom_range(0, 65535)));
  endtask

  // Stop sending and wait until every queued result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_LIMIT:        lim_q8    = val;
      CFG_TABLE_SELECT: head_10w  = val[0];
      CFG_HAS_SWITCH:   switch_en = val[0];
      CFG_FAN_DELAY:    fan_delay = val[11:0];
      CFG_SWITCH_DELAY: sw_delay  = val[11:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare each result with the oldest queued prediction
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: pwm_duty %0d", out_ch.pwm_duty);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("pwm_duty", want.duty, out_ch.pwm_duty);
        check_field("applied_power_q8", want.power, out_ch.applied_power_q8);
        check_field("tube_on", want.tube_on, out_ch.tube_on);
        check_field("fan_mode", want.fan_mode, out_ch.fan_mode);
        check_field("switch_mode", want.switch_mode, out_ch.switch_mode);
        check_field("fan_command", want.fan_cmd, out_ch.fan_command);
        check_field("switch_command", want.switch_cmd, out_ch.switch_command);
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls before each result
  initial begin
    int n;
    int served;
    served       = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = draw_wait(rx_mode);
      repeat (n) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      served++;
      if (served % 40 == 0) rx_mode = $urandom_range(0, 2);
    end
  end

  // Outputs straight after reset
  task automatic test_reset_state();
    send_request(CMD_TICK, 16'h0000);
    send_request(CMD_SET_POWER, 16'h0000);
  endtask

  // Both curves: saturation, top index, fractions
  task automatic test_power_curve();
    send_request(CMD_SET_POWER, 16'hFFFF);
    send_request(CMD_SET_POWER, 16'(FULL_POWER_Q));
    send_request(CMD_SET_POWER, 16'(FULL_POWER_Q) - 16'd1);
    send_request(CMD_SET_POWER, 16'h0180);
    send_request(CMD_SET_POWER, 16'h0001);
    send_request(CMD_SET_POWER, 16'h8000);
    write_reg(CFG_TABLE_SELECT, 15'd1);
    send_request(CMD_SET_POWER, 16'(FULL_POWER_Q));
    send_request(CMD_SET_POWER, 16'h0100);
    send_request(CMD_SET_POWER, 16'h6380);
  endtask

  // Power limit at zero, above full scale and in between
  task automatic test_limit_clamp();
    write_reg(CFG_LIMIT, 15'd0);
    send_request(CMD_SET_POWER, 16'hFFFF);
    write_reg(CFG_LIMIT, 15'h7FFF);
    send_request(CMD_SET_POWER, 16'hFFFF);
    write_reg(CFG_LIMIT, 15'h1280);
    send_request(CMD_SET_POWER, 16'h5000);
    send_request(CMD_SET_POWER, 16'h1000);
    write_reg(CFG_LIMIT, FULL_POWER_Q);
  endtask

  // Fan and switch delayed off, reopen while waiting, switch disabled
  task automatic test_delayed_off();
    write_reg(CFG_HAS_SWITCH, 15'd1);
    write_reg(CFG_FAN_DELAY, 15'd0);
    write_reg(CFG_SWITCH_DELAY, 15'd2);
    send_request(CMD_SET_POWER, 16'h0A00);
    send_request(CMD_SET_POWER, 16'h0000);
    send_ticks(1);
    send_request(CMD_SET_POWER, 16'h0100);
    send_request(CMD_SET_POWER, 16'h0000);
    send_ticks(3);
    write_reg(CFG_HAS_SWITCH, 15'd0);
    send_request(CMD_SET_POWER, 16'h0A00);
    send_request(CMD_SET_POWER, 16'h0000);
    send_ticks(1);
    write_reg(CFG_FAN_DELAY, 15'd4095);
    write_reg(CFG_SWITCH_DELAY, 15'd0);
  endtask

  function automatic logic [REQ_W-1:0] draw_power();
    case ($urandom_range(0, 5))
      1: return REQ_W'($urandom_range(0, 65535));
      2: return REQ_W'($urandom_range(25400, 25800));
      3: return REQ_W'($urandom_range(0, 25600));
      4: return REQ_W'($urandom_range(1, 511));
      default: return '0;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return FULL_POWER_Q;
      2: return 15'h7FFF;
      default: return CFG_W'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [11:0] draw_delay();
    return ($urandom_range(0, 7) == 0) ? 12'd4095 : 12'($urandom_range(0, 24));
  endfunction

  // Random phases: power requests followed by runs of ticks, plus some noise
  task automatic test_random_traffic();
    int sent;
    int span;
    int ticks;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_LIMIT, draw_limit());
      write_reg(CFG_TABLE_SELECT, CFG_W'($urandom_range(0, 1)));
      write_reg(CFG_HAS_SWITCH, CFG_W'($urandom_range(0, 1)));
      write_reg(CFG_FAN_DELAY, CFG_W'(draw_delay()));
      write_reg(CFG_SWITCH_DELAY, CFG_W'(draw_delay()));
      tx_mode = $urandom_range(0, 2);
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 15) == 0) tx_mode = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) begin
          send_request(logic'($urandom_range(0, 1)), REQ_W'($urandom_range(0, 65535)));
          sent++;
        end else begin
          send_request(CMD_SET_POWER, draw_power());
          span = (fan_delay > sw_delay) ? int'(fan_delay) : int'(sw_delay);
          if (span > 40) span = 40;
          ticks = $urandom_range(0, span + 3);
          send_ticks(ticks);
          sent += 1 + ticks;
        end
      end
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_SET_POWER;
    in_ch.power_q8 = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_LIMIT;
    cfg_data       = '0;
    rst_n          = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_power_curve();
    test_limit_clamp();
    test_delayed_off();
    test_random_traffic();
    drain_results();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_ifs.sv
hw/rtl/lpd_curve_interp.sv
hw/rtl/lpd_delay_off.sv
hw/rtl/laser_power_drive_with_delayed_off_unit.sv
sim/laser_power_drive_with_delayed_off_unit_tb.sv
